// ===== sv/clnw_pkg.sv =====
package clnw_pkg;

  // Width of the request value field.
  localparam int VALUE_W = 16;

  // Default number of value bits taken into a decimal conversion.
  localparam int VALUE_BITS_DEF = 16;

  // Cursor base addresses.
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  // High nibble of an ASCII decimal digit ('0' is 0x30).
  localparam logic [3:0] DIGIT_HI = 4'h3;

  // Rows that produce writes.
  localparam logic [1:0] ROW_ONE = 2'd1;
  localparam logic [1:0] ROW_TWO = 2'd2;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_NUMBER = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_t;

  // Decimal digits needed for the largest number of the given bit width.
  function automatic int num_digits(input int bits);
    longint unsigned v;
    int d;
    begin
      v = (longint'(1) << bits) - 1;
      d = 0;
      while (v > 0) begin
        v = v / 10;
        d = d + 1;
      end
      return d;
    end
  endfunction

endpackage

// ===== sv/clnw_if.sv =====
interface clnw_req_if import clnw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [1:0]         row;
  logic [7:0]         column;

  modport source (output valid, kind, value, row, column, input ready);
  modport sink   (input valid, kind, value, row, column, output ready);
endinterface

interface clnw_wr_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, register_select, nibble, last, input ready);
  modport sink   (input valid, register_select, nibble, last, output ready);
endinterface

// ===== sv/char_lcd_nibble_writer_core.sv =====
// Command: 1 write; ST_EMIT loads it into the write register, and the next item is taken back in ST_IDLE.
// Character / cursor: 2 writes (none for a cursor on rows 0 and 3), one per cycle while the bus takes them.
// Number: bit-serial binary-to-BCD conversion of NUM_BITS bits, one ST_SKIP step per dropped leading zero
//   plus one to find the first digit, then 2 writes per digit.
// The write register lets a new item in while the last write of the previous one waits.
// rst is synchronous: sequencer returns to idle and the write register empties.
module char_lcd_nibble_writer_core import clnw_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  clnw_req_if.sink    req,
  clnw_wr_if.source   wr
);

  // Only bits that exist on the value port can take part.
  localparam int NUM_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int NDIG     = num_digits(NUM_BITS);
  localparam int BCD_W    = NDIG * 4;
  localparam int BCW      = $clog2(NUM_BITS);
  localparam int CW       = $clog2(NDIG + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for an item
    ST_CONV = 4'b0010,  // shift-add-3 conversion, one bit a cycle
    ST_SKIP = 4'b0100,  // drop leading zero digits
    ST_EMIT = 4'b1000   // hand nibbles to the write register
  } state_t;

  state_t              state, state_next;
  logic [NUM_BITS-1:0] bin, bin_next;     // binary shifter feeding the BCD chain
  logic [BCD_W-1:0]    bcd, bcd_next;     // digits, or the byte or nibble to send, MSB first
  logic [BCW-1:0]      bitcnt, bitcnt_next;
  logic [CW-1:0]       cnt, cnt_next;     // digits left (number) or nibbles left
  logic                is_num, is_num_next;
  logic                sel, sel_next;
  logic                half, half_next;   // number: 0 = '3' nibble, 1 = digit nibble

  // Write register
  logic       out_valid, out_valid_next;
  logic       out_sel, out_sel_next;
  logic [3:0] out_nib, out_nib_next;
  logic       out_last, out_last_next;

  logic [BCD_W-1:0] bcd_adj;
  logic [3:0]       top;
  logic             slot_free;
  logic [7:0]       cur_base;
  logic [7:0]       cur_addr;

  assign top       = bcd[BCD_W-1 -: 4];
  assign slot_free = !out_valid || wr.ready;
  assign req.ready = (state == ST_IDLE);

  assign cur_base = (req.row == ROW_ONE) ? ROW1_BASE : ROW2_BASE;
  assign cur_addr = cur_base + req.column - 8'd1;

  // Add-3 correction on every digit before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    state_next     = state;
    bin_next       = bin;
    bcd_next       = bcd;
    bitcnt_next    = bitcnt;
    cnt_next       = cnt;
    is_num_next    = is_num;
    sel_next       = sel;
    half_next      = half;
    out_valid_next = out_valid && !wr.ready;
    out_sel_next   = out_sel;
    out_nib_next   = out_nib;
    out_last_next  = out_last;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          bcd_next    = '0;
          half_next   = 1'b0;
          is_num_next = 1'b0;
          case (req.kind)
            KIND_CMD: begin
              bcd_next[BCD_W-1 -: 4] = req.value[3:0];
              cnt_next   = CW'(1);
              sel_next   = 1'b0;
              state_next = ST_EMIT;
            end
            KIND_CHAR: begin
              bcd_next[BCD_W-1 -: 8] = req.value[7:0];
              cnt_next   = CW'(2);
              sel_next   = 1'b1;
              state_next = ST_EMIT;
            end
            KIND_NUMBER: begin
              bin_next    = req.value[NUM_BITS-1:0];
              bitcnt_next = BCW'(NUM_BITS - 1);
              is_num_next = 1'b1;
              sel_next    = 1'b1;
              state_next  = ST_CONV;
            end
            KIND_CURSOR: begin
              // Rows 0 and 3 produce nothing; the item is simply taken.
              if (req.row == ROW_ONE || req.row == ROW_TWO) begin
                bcd_next[BCD_W-1 -: 8] = cur_addr;
                cnt_next   = CW'(2);
                sel_next   = 1'b0;
                state_next = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_CONV: begin
        bcd_next = {bcd_adj[BCD_W-2:0], bin[NUM_BITS-1]};
        bin_next = {bin[NUM_BITS-2:0], 1'b0};
        if (bitcnt == '0) begin
          cnt_next   = CW'(NDIG);
          state_next = ST_SKIP;
        end else begin
          bitcnt_next = bitcnt - BCW'(1);
        end
      end

      ST_SKIP: begin
        // Zero keeps its last digit.
        if (top == 4'd0 && cnt > CW'(1)) begin
          bcd_next = {bcd[BCD_W-5:0], 4'd0};
          cnt_next = cnt - CW'(1);
        end else begin
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_sel_next   = sel;
          if (is_num && !half) begin
            out_nib_next  = DIGIT_HI;
            out_last_next = 1'b0;
            half_next     = 1'b1;
          end else begin
            out_nib_next  = top;
            out_last_next = (cnt == CW'(1));
            half_next     = 1'b0;
            bcd_next      = {bcd[BCD_W-5:0], 4'd0};
            cnt_next      = cnt - CW'(1);
            if (cnt == CW'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    bin      <= bin_next;
    bcd      <= bcd_next;
    bitcnt   <= bitcnt_next;
    cnt      <= cnt_next;
    is_num   <= is_num_next;
    sel      <= sel_next;
    half     <= half_next;
    out_sel  <= out_sel_next;
    out_nib  <= out_nib_next;
    out_last <= out_last_next;
  end

  assign wr.valid           = out_valid;
  assign wr.register_select = out_sel;
  assign wr.nibble          = out_nib;
  assign wr.last            = out_last;

endmodule
